// ----- rtl/sqmm_pkg.sv -----
// Shared types and constants for the square matrix multiplier.
// Used by sqmm_mac and square_matrix_multiply; no dependencies.
package sqmm_pkg;

  // Largest matrix dimension supported by default
  localparam int DimMaxDef = 8;

  // Field widths fixed by the stream format
  localparam int IdxW  = 3;
  localparam int ValW  = 32;
  localparam int SizeW = 4;
  localparam int FracW = 16;

  // Stream bus widths (fields packed, padded to whole bytes)
  localparam int InDataW  = 40;
  localparam int OutDataW = 40;
  localparam int OpW      = 2;

  localparam logic [SizeW-1:0] SizeRst = SizeW'(8);

  // Saturation limits for a Q16.16 result
  localparam logic [ValW-1:0] ValMax = {1'b0, {(ValW-1){1'b1}}};
  localparam logic [ValW-1:0] ValMin = {1'b1, {(ValW-1){1'b0}}};

  // Word opcodes carried in s_axis_tuser
  typedef enum logic [OpW-1:0] {
    OP_WR_LEFT  = 2'd0,
    OP_WR_RIGHT = 2'd1,
    OP_COMPUTE  = 2'd2
  } opcode_e;

  // Status of the multiply-accumulate unit toward the sequencer
  typedef struct packed {
    logic            done;   // dot product complete
    logic            sat;    // result was clipped
    logic [ValW-1:0] value;  // saturated Q16.16 result
  } mac_res_t;

endpackage

// ----- rtl/sqmm_mac.sv -----
// Shared multiply-accumulate unit: registered 32x32 multiply, wide accumulator,
// shift by the fraction width and saturation. Depends on sqmm_pkg.
module sqmm_mac import sqmm_pkg::*; #(
  parameter int DIM_MAX = DimMaxDef
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            clear_i,  // start a new dot product
  input  logic            vld_i,    // operand pair valid
  input  logic            last_i,   // last operand pair of the dot product
  input  logic [ValW-1:0] a_i,
  input  logic [ValW-1:0] b_i,
  output mac_res_t        res_o
);

  localparam int ProdW = 2 * ValW;
  localparam int AccW  = ProdW + $clog2(DIM_MAX) + 1;
  localparam int TopLo = FracW + ValW - 1;

  logic signed [ProdW-1:0] prod_q;
  logic                    pv_q, pl_q;
  logic signed [AccW-1:0]  acc_q;
  logic                    done_q;
  logic [AccW-1:TopLo]     acc_top;
  logic                    fits;

  // Multiply stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pv_q <= 1'b0;
      pl_q <= 1'b0;
    end else begin
      pv_q <= vld_i & ~clear_i;
      pl_q <= last_i;
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= $signed(a_i) * $signed(b_i);
  end

  // Accumulate stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q  <= '0;
      done_q <= 1'b0;
    end else if (clear_i) begin
      acc_q  <= '0;
      done_q <= 1'b0;
    end else if (pv_q) begin
      acc_q  <= acc_q + {{(AccW-ProdW){prod_q[ProdW-1]}}, prod_q};
      done_q <= pl_q;
    end
  end

  // Shift right by the fraction width and clip to 32 bits
  assign acc_top = acc_q[AccW-1:TopLo];
  assign fits    = (&acc_top) | ~(|acc_top);

  always_comb begin
    res_o.done  = done_q;
    res_o.sat   = ~fits;
    res_o.value = fits ? acc_q[TopLo:FracW] : (acc_q[AccW-1] ? ValMin : ValMax);
  end

endmodule

// ----- rtl/square_matrix_multiply.sv -----
// Square matrix multiplier: left and right element stores and the sequencer.
// Depends on sqmm_pkg and sqmm_mac.
//
// Usage: words enter on s_axis; tuser holds the opcode. Write-left and
// write-right words store element_value at (row_index, col_index). A compute
// word emits the n x n product (n = matrix_size, clamped to 1..DIM_MAX) on
// m_axis in row-major order, tlast on the final element, tuser set when an
// element saturated.
// Each product element runs its n operand pairs through one shared
// multiply-accumulate unit: pairs are issued in turn through the store read
// registers, the multiplier and the accumulator, and the result goes into the
// output register; a compute word is paced by that single unit and the one
// read port of each store. s_axis_tready is low for the whole compute.
// The output register holds a word until the receiver takes it; while
// m_axis_tready is low the sequencer waits before loading the next element,
// and a store write may be accepted while the final word still waits. Reset
// sets matrix_size to 8 and empties the output; store contents are undefined
// until written. Write matrix_size via cfg_we_i only while idle; not enforced.
module square_matrix_multiply import sqmm_pkg::*; #(
  parameter int DIM_MAX = DimMaxDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  // configuration
  input  logic                cfg_we_i,
  input  logic [SizeW-1:0]    cfg_wdata_i,    // matrix_size
  // input word stream
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [InDataW-1:0]  s_axis_tdata,   // row_index[2:0], col_index[5:3],
                                              // element_value[37:6]
  input  logic [OpW-1:0]      s_axis_tuser,   // opcode[1:0]
  // result word stream
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  output logic [OutDataW-1:0] m_axis_tdata,   // out_row[2:0], out_col[5:3],
                                              // product_value[37:6]
  output logic                m_axis_tuser,   // saturated[0]
  output logic                m_axis_tlast    // last_element
);

  localparam int Depth = DIM_MAX * DIM_MAX;
  localparam int AddrW = (Depth > 1) ? $clog2(Depth) : 1;

  typedef enum logic [1:0] {
    S_IDLE,
    S_MAC,
    S_DRAIN
  } state_e;

  // Input fields
  logic [IdxW-1:0] in_row, in_col;
  logic [ValW-1:0] in_val;
  opcode_e         in_op;
  logic            in_acc;

  assign in_row = s_axis_tdata[IdxW-1:0];
  assign in_col = s_axis_tdata[2*IdxW-1:IdxW];
  assign in_val = s_axis_tdata[2*IdxW+ValW-1:2*IdxW];
  assign in_op  = opcode_e'(s_axis_tuser);

  state_e          state_q;
  logic [SizeW-1:0] size_q;
  logic [IdxW-1:0] nl_q, i_q, j_q, k_q;
  logic            v1_q, last1_q;
  logic            m_valid_q;
  logic [IdxW-1:0] o_row_q, o_col_q;
  logic [ValW-1:0] o_val_q;
  logic            o_sat_q, o_last_q;

  logic [ValW-1:0] left_mem  [Depth];
  logic [ValW-1:0] right_mem [Depth];
  logic [ValW-1:0] rd_l_q, rd_r_q;

  logic             wr_ok, wr_left, wr_right;
  logic [AddrW-1:0] waddr, raddr_l, raddr_r;
  logic [SizeW-1:0] size_m1;
  logic [IdxW-1:0]  n_last;
  logic             push, start, elem_last;
  mac_res_t         mac_res;

  assign s_axis_tready = (state_q == S_IDLE);
  assign in_acc        = s_axis_tvalid & s_axis_tready;

  // Store writes, ignored for indexes outside the store
  assign wr_ok    = (int'(in_row) < DIM_MAX) && (int'(in_col) < DIM_MAX);
  assign wr_left  = in_acc && (in_op == OP_WR_LEFT) && wr_ok;
  assign wr_right = in_acc && (in_op == OP_WR_RIGHT) && wr_ok;
  assign waddr    = AddrW'(int'(in_row) * DIM_MAX + int'(in_col));
  assign raddr_l  = AddrW'(int'(i_q) * DIM_MAX + int'(k_q));
  assign raddr_r  = AddrW'(int'(k_q) * DIM_MAX + int'(j_q));

  // Effective size minus one, clamped to 1..DIM_MAX
  assign size_m1 = size_q - SizeW'(1);
  always_comb begin
    if (size_q == '0) begin
      n_last = '0;
    end else if (int'(size_q) > DIM_MAX) begin
      n_last = IdxW'(DIM_MAX - 1);
    end else begin
      n_last = size_m1[IdxW-1:0];
    end
  end

  assign start     = in_acc && (in_op == OP_COMPUTE);
  assign push      = (state_q == S_DRAIN) && mac_res.done &&
                     (!m_valid_q || m_axis_tready);
  assign elem_last = (i_q == nl_q) && (j_q == nl_q);

  // Element stores with registered read
  always_ff @(posedge clk_i) begin
    if (wr_left) begin
      left_mem[waddr] <= in_val;
    end
    rd_l_q <= left_mem[raddr_l];
  end

  always_ff @(posedge clk_i) begin
    if (wr_right) begin
      right_mem[waddr] <= in_val;
    end
    rd_r_q <= right_mem[raddr_r];
  end

  // Configuration register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      size_q <= SizeRst;
    end else if (cfg_we_i) begin
      size_q <= cfg_wdata_i;
    end
  end

  // Sequencer and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      nl_q      <= '0;
      i_q       <= '0;
      j_q       <= '0;
      k_q       <= '0;
      v1_q      <= 1'b0;
      last1_q   <= 1'b0;
      m_valid_q <= 1'b0;
      o_row_q   <= '0;
      o_col_q   <= '0;
      o_val_q   <= '0;
      o_sat_q   <= 1'b0;
      o_last_q  <= 1'b0;
    end else begin
      // issue one operand pair per cycle while in S_MAC
      v1_q    <= (state_q == S_MAC);
      last1_q <= (state_q == S_MAC) && (k_q == nl_q);
      if (m_axis_tready && !push) begin
        m_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (start) begin
            nl_q    <= n_last;
            i_q     <= '0;
            j_q     <= '0;
            k_q     <= '0;
            state_q <= S_MAC;
          end
        end
        S_MAC: begin
          if (k_q == nl_q) begin
            k_q     <= '0;
            state_q <= S_DRAIN;
          end else begin
            k_q <= k_q + IdxW'(1);
          end
        end
        S_DRAIN: begin
          if (push) begin
            m_valid_q <= 1'b1;
            o_row_q   <= i_q;
            o_col_q   <= j_q;
            o_val_q   <= mac_res.value;
            o_sat_q   <= mac_res.sat;
            o_last_q  <= elem_last;
            if (elem_last) begin
              state_q <= S_IDLE;
            end else begin
              state_q <= S_MAC;
              if (j_q == nl_q) begin
                j_q <= '0;
                i_q <= i_q + IdxW'(1);
              end else begin
                j_q <= j_q + IdxW'(1);
              end
            end
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  sqmm_mac #(
    .DIM_MAX(DIM_MAX)
  ) u_mac (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .clear_i(start | push),
    .vld_i  (v1_q),
    .last_i (last1_q),
    .a_i    (rd_l_q),
    .b_i    (rd_r_q),
    .res_o  (mac_res)
  );

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = {{(OutDataW-2*IdxW-ValW){1'b0}}, o_val_q, o_col_q, o_row_q};
  assign m_axis_tuser  = o_sat_q;
  assign m_axis_tlast  = o_last_q;

endmodule
